// File: sv/cbo_pkg.sv
package cbo_pkg;

  localparam int unsigned IN_WIDTH_DEF = 16;
  localparam int unsigned OUT_FRAC_DEF = 14;

  // Unit vectors are carried with 30 fraction bits in a 32-bit signed word.
  localparam int unsigned UNIT_FRAC  = 30;
  localparam int unsigned UNIT_W     = 32;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;

  // Magnitude, leading one, shift, squares and sum take five stages, then
  // the root, one divider setup stage, the divider and the sign stage.
  localparam int unsigned NORM_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] m;
    logic [2:0]            neg;
    logic                  zero;
  } norm_side_t;

endpackage

// File: sv/cbo_if.sv
interface cbo_in_if #(
  parameter int unsigned W = cbo_pkg::IN_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] normal_x;
  logic signed [W-1:0] normal_y;
  logic signed [W-1:0] normal_z;
  logic signed [W-1:0] up_x;
  logic signed [W-1:0] up_y;
  logic signed [W-1:0] up_z;

  modport source (output valid, normal_x, normal_y, normal_z, up_x, up_y, up_z,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, up_x, up_y, up_z,
                output ready);
endinterface

interface cbo_out_if #(
  parameter int unsigned OW = cbo_pkg::OUT_FRAC_DEF + 2
);
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] u_x;
  logic signed [OW-1:0] u_y;
  logic signed [OW-1:0] u_z;
  logic signed [OW-1:0] v_x;
  logic signed [OW-1:0] v_y;
  logic signed [OW-1:0] v_z;
  logic signed [OW-1:0] n_x;
  logic signed [OW-1:0] n_y;
  logic signed [OW-1:0] n_z;
  logic                 degenerate;

  modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, n_x, n_y, n_z,
                  degenerate, input ready);
  modport sink (input valid, u_x, u_y, u_z, v_x, v_y, v_z, n_x, n_y, n_z,
                degenerate, output ready);
endinterface

// File: sv/cbo_delay.sv
module cbo_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= data_i;
      for (int k = 1; k < int'(DEPTH); k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign data_o = sr_q[DEPTH-1];

endmodule

// File: sv/cbo_norm.sv
module cbo_norm #(
  parameter int unsigned W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] vec_i [3],
  output logic                valid_o,
  output logic                zero_o,
  output cbo_pkg::unit_t      vec_o [3]
);
  import cbo_pkg::*;

  localparam int unsigned PW  = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned EW  = W + UNIT_FRAC;
  localparam int unsigned SQW = 2 * MAG_W;
  localparam int unsigned DVW = MAG_W + UNIT_FRAC + 1;

  // Stage A: magnitudes, signs and the largest magnitude.
  logic [W-1:0] mag_a_d [3];
  logic [W-1:0] big_a_d;
  logic [W-1:0] mag_a_q [3];
  logic [W-1:0] big_a_q;
  logic [2:0]   neg_a_q;
  logic         vld_a_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a_d[i] = vec_i[i][W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    big_a_d = mag_a_d[0];
    if (mag_a_d[1] > big_a_d) big_a_d = mag_a_d[1];
    if (mag_a_d[2] > big_a_d) big_a_d = mag_a_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_a_d;
      big_a_q <= big_a_d;
      neg_a_q <= {vec_i[2][W-1], vec_i[1][W-1], vec_i[0][W-1]};
    end
  end

  // Stage B: position of the leading one of the largest magnitude.
  logic [PW-1:0] pos_b_d;
  logic [PW-1:0] pos_b_q;
  logic [W-1:0]  mag_b_q [3];
  logic [2:0]    neg_b_q;
  logic          zero_b_q;
  logic          vld_b_q;

  always_comb begin
    pos_b_d = '0;
    for (int b = 0; b < int'(W); b++) begin
      if (big_a_q[b]) pos_b_d = PW'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_b_q  <= pos_b_d;
      mag_b_q  <= mag_a_q;
      neg_b_q  <= neg_a_q;
      zero_b_q <= (big_a_q == '0);
    end
  end

  // Stage C: scale so that the largest magnitude lands in [2^30, 2^31).
  // Shifting up by 30 and then down by the leading-one position truncates
  // exactly like a sequence of single-bit right shifts.
  logic [EW-1:0] shf_c_d [3];
  norm_side_t    side_c_q;
  logic          vld_c_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf_c_d[i] = ({{UNIT_FRAC{1'b0}}, mag_b_q[i]} << UNIT_FRAC) >> pos_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        side_c_q.m[i] <= shf_c_d[i][MAG_W-1:0];
      end
      side_c_q.neg  <= neg_b_q;
      side_c_q.zero <= zero_b_q;
    end
  end

  // Stage D: squares.
  logic [SQW-1:0] sq_d_q [3];
  norm_side_t     side_d_q;
  logic           vld_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_d_q[i] <= SQW'(side_c_q.m[i]) * SQW'(side_c_q.m[i]);
      end
      side_d_q <= side_c_q;
    end
  end

  // Stage E feeds the root pipeline: one result bit per stage.
  logic [63:0] rt_s_q    [SQRT_STEPS+1];
  logic [63:0] rt_r_q    [SQRT_STEPS+1];
  norm_side_t  rt_side_q [SQRT_STEPS+1];
  logic        rt_vld_q  [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      rt_vld_q[0] <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_s_q[0]    <= 64'(sq_d_q[0]) + 64'(sq_d_q[1]) + 64'(sq_d_q[2]);
      rt_r_q[0]    <= '0;
      rt_side_q[0] <= side_d_q;
    end
  end

  for (genvar k = 0; k < int'(SQRT_STEPS); k++) begin : g_root
    localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    assign trial = rt_r_q[k] + RBIT;
    assign take  = (rt_s_q[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_s_q[k+1]    <= take ? (rt_s_q[k] - trial) : rt_s_q[k];
        rt_r_q[k+1]    <= take ? ((rt_r_q[k] >> 1) + RBIT) : (rt_r_q[k] >> 1);
        rt_side_q[k+1] <= rt_side_q[k];
      end
    end
  end

  // Divider setup: dividend is m * 2^30 plus half the root.
  logic [31:0]           root;
  logic [2:0][DVW-1:0]   dv_dvd_q  [DIV_STEPS+1];
  logic [2:0][31:0]      dv_rem_q  [DIV_STEPS+1];
  logic [2:0][MAG_W-1:0] dv_quo_q  [DIV_STEPS+1];
  logic [31:0]           dv_root_q [DIV_STEPS+1];
  logic [2:0]            dv_neg_q  [DIV_STEPS+1];
  logic                  dv_zero_q [DIV_STEPS+1];
  logic                  dv_vld_q  [DIV_STEPS+1];
  logic [2:0][DVW-1:0]   dvd_x_d;

  assign root = rt_r_q[SQRT_STEPS][31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd_x_d[i] = {rt_side_q[SQRT_STEPS].m[i], {UNIT_FRAC{1'b0}}} + DVW'(root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= rt_vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= 32'(dvd_x_d[i][DVW-1:DIV_STEPS]);
      end
      dv_dvd_q[0]  <= dvd_x_d;
      dv_quo_q[0]  <= '0;
      dv_root_q[0] <= root;
      dv_neg_q[0]  <= rt_side_q[SQRT_STEPS].neg;
      dv_zero_q[0] <= rt_side_q[SQRT_STEPS].zero;
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes.
  for (genvar j = 0; j < int'(DIV_STEPS); j++) begin : g_div
    localparam int unsigned B = DIV_STEPS - 1 - j;
    logic [32:0] rem2 [3];
    logic [2:0]  take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {dv_rem_q[j][i], dv_dvd_q[j][i][B]};
        take[i] = (rem2[i] >= {1'b0, dv_root_q[j]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= take[i] ? 32'(rem2[i] - {1'b0, dv_root_q[j]})
                                      : 32'(rem2[i]);
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][MAG_W-2:0], take[i]};
        end
        dv_dvd_q[j+1]  <= dv_dvd_q[j];
        dv_root_q[j+1] <= dv_root_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end
  end

  // Sign stage.
  logic valid_q;
  logic zero_q;
  unit_t vec_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        vec_q[i] <= dv_neg_q[DIV_STEPS][i] ? -unit_t'(dv_quo_q[DIV_STEPS][i])
                                           : unit_t'(dv_quo_q[DIV_STEPS][i]);
      end
      zero_q <= dv_zero_q[DIV_STEPS];
    end
  end

  assign valid_o = valid_q;
  assign zero_o  = zero_q;
  assign vec_o   = vec_q;

endmodule

// File: sv/camera_basis_orthonormalize.sv
// Camera basis orthonormalization.
// The in_i channel takes a view normal and an up hint, signed Q8.8 by default.
// The out_o channel returns the unit axes u, v and n in signed Q2.14 by default,
// with a degenerate flag; when it is set all nine axes are zero.
// Both channels use a valid/ready handshake; a transaction completes on a clock
// edge where both are high.
// From input transaction to output valid a result passes three normalizer
// pipelines of 70 stages each (mostly the bit-per-stage square root and
// divider), three stages for the dot product, two for removing the normal
// component, two for the cross product and the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops in the same cycle, so nothing is lost or repeated.
module camera_basis_orthonormalize #(
  parameter int unsigned IN_WIDTH      = cbo_pkg::IN_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = cbo_pkg::OUT_FRAC_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  cbo_in_if.sink    in_i,
  cbo_out_if.source out_o
);
  import cbo_pkg::*;

  localparam int unsigned OUT_WIDTH = OUT_FRAC_BITS + 2;
  localparam int unsigned SH        = UNIT_FRAC - OUT_FRAC_BITS;
  localparam int unsigned RW        = UNIT_W + 2;
  localparam int unsigned DW        = 35;
  localparam int unsigned PW        = UNIT_W + DW;
  localparam int unsigned WW        = 36;
  localparam int unsigned CW        = 64;

  function automatic logic [OUT_WIDTH-1:0] to_out(unit_t x);
    logic [UNIT_W-1:0] mag;
    logic [RW-1:0]     sum;
    logic [UNIT_W-1:0] r;
    mag = x[UNIT_W-1] ? UNIT_W'(-x) : UNIT_W'(x);
    sum = {1'b0, mag, 1'b0} + (RW'(1) << SH);
    r   = UNIT_W'(sum >> (SH + 1));
    return x[UNIT_W-1] ? OUT_WIDTH'(-r) : OUT_WIDTH'(r);
  endfunction

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Normalize the view normal and the up hint side by side.
  logic signed [IN_WIDTH-1:0] nraw [3];
  logic signed [IN_WIDTH-1:0] uraw [3];
  unit_t n_n [3];
  unit_t uh_n [3];
  logic  vld_n, vld_uh, z_n, z_uh;

  assign nraw = '{in_i.normal_x, in_i.normal_y, in_i.normal_z};
  assign uraw = '{in_i.up_x, in_i.up_y, in_i.up_z};

  cbo_norm #(.W(IN_WIDTH)) u_norm_n (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .vec_i(nraw),
    .valid_o(vld_n), .zero_o(z_n), .vec_o(n_n)
  );

  cbo_norm #(.W(IN_WIDTH)) u_norm_up (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .vec_i(uraw),
    .valid_o(vld_uh), .zero_o(z_uh), .vec_o(uh_n)
  );

  // Dot product of up and n, then removal of the component along n.
  logic signed [CW-1:0] dp_d1_q [3];
  logic signed [CW-1:0] dsum_d2_q;
  logic signed [DW-1:0] d_d3_q;
  logic signed [PW-1:0] p_w1_q [3];
  logic signed [WW-1:0] w_w2_q [3];
  unit_t n_d1_q [3], n_d2_q [3], n_d3_q [3], n_w1_q [3], n_w2_q [3];
  unit_t uh_d1_q [3], uh_d2_q [3], uh_d3_q [3], uh_w1_q [3];
  logic  flg_d1_q, flg_d2_q, flg_d3_q, flg_w1_q, flg_w2_q;
  logic  vld_d1_q, vld_d2_q, vld_d3_q, vld_w1_q, vld_w2_q;

  logic [CW-1:0]        dmag;
  logic [DW-2:0]        dmr;
  logic [PW-1:0]        pmag [3];
  logic [WW:0]          pmr  [3];
  logic signed [WW+1:0] wfull [3];

  always_comb begin
    dmag = dsum_d2_q[CW-1] ? CW'(-dsum_d2_q) : CW'(dsum_d2_q);
    dmr  = (DW-1)'((dmag + (CW'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC);
    for (int i = 0; i < 3; i++) begin
      pmag[i]  = p_w1_q[i][PW-1] ? PW'(-p_w1_q[i]) : PW'(p_w1_q[i]);
      pmr[i]   = (WW+1)'((pmag[i] + (PW'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC);
      wfull[i] = (WW+2)'(uh_w1_q[i])
               - (p_w1_q[i][PW-1] ? -(WW+2)'(pmr[i]) : (WW+2)'(pmr[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d1_q <= 1'b0;
      vld_d2_q <= 1'b0;
      vld_d3_q <= 1'b0;
      vld_w1_q <= 1'b0;
      vld_w2_q <= 1'b0;
    end else if (en) begin
      vld_d1_q <= vld_n;
      vld_d2_q <= vld_d1_q;
      vld_d3_q <= vld_d2_q;
      vld_w1_q <= vld_d3_q;
      vld_w2_q <= vld_w1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_d1_q[i] <= CW'(n_n[i]) * CW'(uh_n[i]);
        p_w1_q[i]  <= PW'(n_d3_q[i]) * PW'(d_d3_q);
        w_w2_q[i]  <= WW'(wfull[i]);
      end
      dsum_d2_q <= dp_d1_q[0] + dp_d1_q[1] + dp_d1_q[2];
      d_d3_q    <= dsum_d2_q[CW-1] ? -DW'(dmr) : DW'(dmr);
      n_d1_q    <= n_n;
      n_d2_q    <= n_d1_q;
      n_d3_q    <= n_d2_q;
      n_w1_q    <= n_d3_q;
      n_w2_q    <= n_w1_q;
      uh_d1_q   <= uh_n;
      uh_d2_q   <= uh_d1_q;
      uh_d3_q   <= uh_d2_q;
      uh_w1_q   <= uh_d3_q;
      flg_d1_q  <= z_n || z_uh;
      flg_d2_q  <= flg_d1_q;
      flg_d3_q  <= flg_d2_q;
      flg_w1_q  <= flg_d3_q;
      flg_w2_q  <= flg_w1_q;
    end
  end

  // Normalize the remainder to give v; n and the flag wait alongside.
  unit_t v_n [3];
  logic  vld_v, z_w;
  logic [3*UNIT_W:0] nf_in, nf_out;
  unit_t n_v [3];
  logic  flg_v;

  cbo_norm #(.W(WW)) u_norm_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_w2_q), .vec_i(w_w2_q),
    .valid_o(vld_v), .zero_o(z_w), .vec_o(v_n)
  );

  assign nf_in = {n_w2_q[2], n_w2_q[1], n_w2_q[0], flg_w2_q};

  cbo_delay #(.WIDTH(3*UNIT_W+1), .DEPTH(NORM_LAT)) u_dly_v (
    .clk_i, .en_i(en), .data_i(nf_in), .data_o(nf_out)
  );

  assign n_v[0] = nf_out[UNIT_W:1];
  assign n_v[1] = nf_out[2*UNIT_W:UNIT_W+1];
  assign n_v[2] = nf_out[3*UNIT_W:2*UNIT_W+1];
  assign flg_v  = nf_out[0] || z_w;

  // Cross product v x n.
  logic signed [CW-1:0] cp_c1_q [6];
  logic signed [CW-1:0] c_c2_q [3];
  unit_t v_c1_q [3], v_c2_q [3], n_c1_q [3], n_c2_q [3];
  logic  flg_c1_q, flg_c2_q, vld_c1_q, vld_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c1_q <= 1'b0;
      vld_c2_q <= 1'b0;
    end else if (en) begin
      vld_c1_q <= vld_v;
      vld_c2_q <= vld_c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_c1_q[0] <= CW'(v_n[1]) * CW'(n_v[2]);
      cp_c1_q[1] <= CW'(n_v[1]) * CW'(v_n[2]);
      cp_c1_q[2] <= CW'(n_v[0]) * CW'(v_n[2]);
      cp_c1_q[3] <= CW'(v_n[0]) * CW'(n_v[2]);
      cp_c1_q[4] <= CW'(v_n[0]) * CW'(n_v[1]);
      cp_c1_q[5] <= CW'(n_v[0]) * CW'(v_n[1]);
      c_c2_q[0]  <= cp_c1_q[0] - cp_c1_q[1];
      c_c2_q[1]  <= cp_c1_q[2] - cp_c1_q[3];
      c_c2_q[2]  <= cp_c1_q[4] - cp_c1_q[5];
      v_c1_q     <= v_n;
      v_c2_q     <= v_c1_q;
      n_c1_q     <= n_v;
      n_c2_q     <= n_c1_q;
      flg_c1_q   <= flg_v;
      flg_c2_q   <= flg_c1_q;
    end
  end

  // Normalize the cross product to give u.
  unit_t u_n [3];
  logic  vld_u, z_c;
  logic [6*UNIT_W:0] vn_in, vn_out;
  unit_t v_u [3], n_u [3];
  logic  degen;

  cbo_norm #(.W(CW)) u_norm_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_c2_q), .vec_i(c_c2_q),
    .valid_o(vld_u), .zero_o(z_c), .vec_o(u_n)
  );

  assign vn_in = {v_c2_q[2], v_c2_q[1], v_c2_q[0],
                  n_c2_q[2], n_c2_q[1], n_c2_q[0], flg_c2_q};

  cbo_delay #(.WIDTH(6*UNIT_W+1), .DEPTH(NORM_LAT)) u_dly_u (
    .clk_i, .en_i(en), .data_i(vn_in), .data_o(vn_out)
  );

  assign n_u[0] = vn_out[UNIT_W:1];
  assign n_u[1] = vn_out[2*UNIT_W:UNIT_W+1];
  assign n_u[2] = vn_out[3*UNIT_W:2*UNIT_W+1];
  assign v_u[0] = vn_out[4*UNIT_W:3*UNIT_W+1];
  assign v_u[1] = vn_out[5*UNIT_W:4*UNIT_W+1];
  assign v_u[2] = vn_out[6*UNIT_W:5*UNIT_W+1];
  assign degen  = vn_out[0] || z_c;

  // Output register.
  logic [OUT_WIDTH-1:0] ax_q [9];
  logic                 degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_u;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax_q[i]   <= degen ? '0 : to_out(u_n[i]);
        ax_q[3+i] <= degen ? '0 : to_out(v_u[i]);
        ax_q[6+i] <= degen ? '0 : to_out(n_u[i]);
      end
      degen_q <= degen;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.u_x        = ax_q[0];
  assign out_o.u_y        = ax_q[1];
  assign out_o.u_z        = ax_q[2];
  assign out_o.v_x        = ax_q[3];
  assign out_o.v_y        = ax_q[4];
  assign out_o.v_z        = ax_q[5];
  assign out_o.n_x        = ax_q[6];
  assign out_o.n_y        = ax_q[7];
  assign out_o.n_z        = ax_q[8];
  assign out_o.degenerate = degen_q;

  localparam logic signed [OUT_WIDTH-1:0] LIM = OUT_WIDTH'(1) << OUT_FRAC_BITS;

  // The two front normalizers run in lock step.
  a_front_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_n == vld_uh)
    else $error("front normalizer valid bits disagree");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && degen_q |-> ax_q[0] == '0 && ax_q[4] == '0 && ax_q[8] == '0)
    else $error("degenerate result carries nonzero axes");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !degen_q |-> $signed(ax_q[6]) <= LIM && $signed(ax_q[6]) >= -LIM)
    else $error("n_x out of unit range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_d3_q) && $stable(vld_c2_q))
    else $error("pipeline moved during stall");

endmodule
